// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; clock clk_i and reset rst_ni are expected in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/lcd4_pkg.sv =====
// types, codes and constants for the 4-bit character lcd write sequencer
// no dependencies
package lcd4_pkg;

  localparam int unsigned HoldW = 20;
  localparam logic [HoldW-1:0] HoldTicksReset = 20'd5000;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_INSTR  = 3'd1;
  localparam logic [2:0] FUNC_DATA   = 3'd2;
  localparam logic [2:0] FUNC_NIBBLE = 3'd3;
  localparam logic [2:0] FUNC_CURSOR = 3'd4;
  localparam logic [2:0] FUNC_INIT   = 3'd5;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HIGH  = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  localparam logic [3:0] InitLen     = 4'd8;
  localparam logic [3:0] InitNibbles = 4'd4;
  localparam logic [7:0] CursorBase  = 8'h80;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] row;
  } req_t;

  typedef struct packed {
    logic [3:0] data_pins;
    logic       enable;
    logic       reg_select;
    logic       read_write;
    logic       busy_res;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [HoldW-1:0] wait_cnt;
    logic [7:0]       held_byte;
    logic             held_rs;
    logic             nibble_only;
    logic [3:0]       init_step;
  } seq_state_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h30;
      3'd1:    b = 8'h30;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h20;
      3'd4:    b = 8'h28;
      3'd5:    b = 8'h0E;
      3'd6:    b = 8'h01;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/lcd4_seq.sv =====
// transfer sequencer: state registers and combinational next-state and pin logic
// depends on lcd4_pkg
module lcd4_seq import lcd4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  req_t             req_i,
  input  logic [HoldW-1:0] hold_i,
  output res_t             res_o
);

  seq_state_t st_q, st_d;
  logic [HoldW-1:0] hold_eff;

  function automatic seq_state_t begin_xfer(input seq_state_t s, input logic [7:0] b,
                                            input logic rs, input logic nib,
                                            input logic [HoldW-1:0] h);
    seq_state_t n;
    n             = s;
    n.held_byte   = b;
    n.held_rs     = rs;
    n.nibble_only = nib;
    n.phase       = PH_HIGH;
    n.wait_cnt    = h;
    return n;
  endfunction

  function automatic seq_state_t end_xfer(input seq_state_t s, input logic [HoldW-1:0] h);
    seq_state_t n;
    logic [3:0] k;
    n = s;
    k = s.init_step;
    if (k >= 4'd1 && k < InitLen) begin
      n.init_step = k + 4'd1;
      n = begin_xfer(n, init_byte(k[2:0]), 1'b0, (k < InitNibbles), h);
    end else begin
      n.init_step = '0;
      n.phase     = PH_IDLE;
      n.wait_cnt  = '0;
      n.held_rs   = 1'b0;
    end
    return n;
  endfunction

  assign hold_eff = (hold_i == '0) ? HoldW'(1) : hold_i;

  logic busy_now, rej;
  logic [7:0] cursor_cmd;

  assign busy_now   = (st_q.phase != PH_IDLE);
  assign cursor_cmd = CursorBase + {req_i.row, req_i.column};

  always_comb begin
    st_d = st_q;
    rej  = 1'b0;
    if (req_i.func == FUNC_TICK) begin
      unique case (st_q.phase)
        PH_HIGH: begin
          if (st_q.wait_cnt <= HoldW'(1)) begin
            st_d.phase    = PH_GAP;
            st_d.wait_cnt = '0;
          end else begin
            st_d.wait_cnt = st_q.wait_cnt - HoldW'(1);
          end
        end
        PH_GAP: begin
          if (st_q.nibble_only) begin
            st_d = end_xfer(st_q, hold_eff);
          end else begin
            st_d.phase    = PH_LOW;
            st_d.wait_cnt = hold_eff;
          end
        end
        PH_LOW: begin
          if (st_q.wait_cnt <= HoldW'(1)) begin
            st_d.phase    = PH_TRAIL;
            st_d.wait_cnt = hold_eff;
          end else begin
            st_d.wait_cnt = st_q.wait_cnt - HoldW'(1);
          end
        end
        PH_TRAIL: begin
          if (st_q.wait_cnt <= HoldW'(1)) begin
            st_d = end_xfer(st_q, hold_eff);
          end else begin
            st_d.wait_cnt = st_q.wait_cnt - HoldW'(1);
          end
        end
        default: ;
      endcase
    end else if (req_i.func <= FUNC_INIT) begin
      if (busy_now) begin
        rej = 1'b1;
      end else begin
        unique case (req_i.func)
          FUNC_INSTR:  st_d = begin_xfer(st_q, req_i.value, 1'b0, 1'b0, hold_eff);
          FUNC_DATA:   st_d = begin_xfer(st_q, req_i.value, 1'b1, 1'b0, hold_eff);
          FUNC_NIBBLE: st_d = begin_xfer(st_q, req_i.value, 1'b0, 1'b1, hold_eff);
          FUNC_CURSOR: st_d = begin_xfer(st_q, cursor_cmd, 1'b0, 1'b0, hold_eff);
          default: begin
            st_d           = st_q;
            st_d.init_step = 4'd1;
            st_d           = begin_xfer(st_d, init_byte(3'd0), 1'b0, 1'b1, hold_eff);
          end
        endcase
      end
    end
  end

  // pin levels follow the updated state
  always_comb begin
    res_o            = '0;
    res_o.busy_res   = (st_d.phase != PH_IDLE);
    res_o.reg_select = res_o.busy_res & st_d.held_rs;
    res_o.rejected   = rej;
    if (st_d.phase == PH_HIGH) begin
      res_o.data_pins = st_d.held_byte[7:4];
      res_o.enable    = 1'b1;
    end else if (st_d.phase == PH_LOW) begin
      res_o.data_pins = st_d.held_byte[3:0];
      res_o.enable    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (acc_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== hw/rtl/char_lcd_4bit_write_sequencer_unit.sv =====
// a result is written to the output register when it is free, else to the skid entry
// throughput: one request per cycle; an output register plus one skid entry, input stalls while the skid entry is held
// the sequencer next state is combinational from the registered state and is registered when a request is accepted
// reset: asynchronous active low; sequencer idle, output empty, hold_ticks 5000
// top level of the 4-bit character lcd write sequencer
// depends on lcd4_pkg, lcd4_seq and assert_macros.svh
`include "assert_macros.svh"

module char_lcd_4bit_write_sequencer_unit import lcd4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [HoldW-1:0] cfg_data_i
);

  logic [HoldW-1:0] hold_q;
  logic             acc;
  res_t             res;
  res_t             out_q, skid_q;
  logic             out_v_q, skid_v_q;
  logic             out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_v_q;
  assign acc         = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_v_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hold_q <= cfg_data_i;
    end
  end

  lcd4_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .req_i  (in_req_i),
    .hold_i (hold_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= acc;
      end
    end else if (acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res;
      end
    end else if (acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_v_q || out_v_q)
  `ASSERT_NEXT(a_skid_drains, skid_v_q && !out_stall_i, out_v_q && !skid_v_q)
  `ASSERT_ALWAYS(a_enable_busy, !out_v_q || !out_q.enable || out_q.busy_res)
  `ASSERT_ALWAYS(a_rs_busy, !out_v_q || !out_q.reg_select || out_q.busy_res)

endmodule
